// File: design/lzd_pkg.sv
`timescale 1ns / 1ps
package lzd_pkg;

   localparam int WINDOW_SIZE      = 32768;
   localparam int MIN_MATCH        = 3;
   localparam int BYTES_PER_RESULT = 8;
   localparam int WIN_BITS         = $clog2(WINDOW_SIZE);
   localparam int LEN_BITS         = 9;
   localparam int CNT_BITS         = 4;
   localparam int FIFO_DEPTH       = 2;
   localparam int FIFO_IDX_BITS    = $clog2(FIFO_DEPTH);

   // parser phases
   localparam logic [2:0] PH_CONTROL = 3'd0;
   localparam logic [2:0] PH_LITERAL = 3'd1;
   localparam logic [2:0] PH_DIST_LO = 3'd2;
   localparam logic [2:0] PH_DIST_HI = 3'd3;
   localparam logic [2:0] PH_LENGTH  = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_PADDING   = 3'd2;
   localparam logic [2:0] ST_ZERO_DIST = 3'd3;
   localparam logic [2:0] ST_WINDOW    = 3'd4;
   localparam logic [2:0] ST_PRODUCED  = 3'd5;
   localparam logic [2:0] ST_OVERRUN   = 3'd6;
   localparam logic [2:0] ST_TRAILING  = 3'd7;

   // command kinds
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_LIT  = 2'd1;
   localparam logic [1:0] CMD_COPY = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          lit;
      logic [WIN_BITS-1:0] offset;
      logic [LEN_BITS-1:0] len;
      logic [WIN_BITS-1:0] base;
      logic [2:0]          status;
      logic                done;
      logic [31:0]         produced;
   } cmd_type;

endpackage

// File: design/lzd_if.sv
`timescale 1ns / 1ps
interface lzd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] token_byte;
   logic       first_byte;
   logic       final_byte;
   modport source (output valid, token_byte, first_byte, final_byte, input ready);
   modport sink (input valid, token_byte, first_byte, final_byte, output ready);
endinterface

interface lzd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  byte_count;
   logic        last_of_run;
   logic [2:0]  status;
   logic        stream_done;
   logic [31:0] bytes_produced;
   modport source (output valid, data_word, byte_count, last_of_run, status,
                   stream_done, bytes_produced, input ready);
   modport sink (input valid, data_word, byte_count, last_of_run, status,
                 stream_done, bytes_produced, output ready);
endinterface

interface lzd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink (input valid, wdata, output ready);
endinterface

// File: design/lzd_parser.sv
`timescale 1ns / 1ps
module lzd_parser import lzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lzd_req_if.sink     req_chan,
   lzd_csr_if.sink     csr_chan,
   output logic        cmd_valid,
   output cmd_type     cmd_data,
   input  logic        cmd_ready
);

   logic [31:0] expected_ff;
   logic [31:0] prod_ff, prod_in, prod_c;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [2:0]  bi_ff, bi_in;
   logic [7:0]  dlo_ff, dlo_in;
   logic [7:0]  dhi_ff, dhi_in;
   logic [2:0]  err_ff, err_in;
   logic [15:0] match_dist;
   logic [LEN_BITS-1:0] len;
   logic        accept;
   logic        done;
   logic [1:0]  kind;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = cmd_ready;
   assign accept         = req_chan.valid & cmd_ready;

   // hold expected size
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (csr_chan.valid) begin
         expected_ff <= csr_chan.wdata;
      end
   end

   // parse one byte
   always_comb begin
      phase_in   = phase_ff;
      ctrl_in    = ctrl_ff;
      bi_in      = bi_ff;
      dlo_in     = dlo_ff;
      dhi_in     = dhi_ff;
      err_in     = err_ff;
      prod_c     = prod_ff;
      kind       = CMD_NONE;
      done       = 1'b0;
      match_dist = '0;
      len        = '0;
      if (req_chan.first_byte) begin
         phase_in = PH_CONTROL;
         ctrl_in  = '0;
         bi_in    = 3'd7;
         dlo_in   = '0;
         dhi_in   = '0;
         err_in   = ST_OK;
         prod_c   = '0;
      end
      prod_in    = prod_c;
      match_dist = {dhi_in, dlo_in};
      len        = LEN_BITS'(req_chan.token_byte) + LEN_BITS'(MIN_MATCH);
      if (err_in == ST_OK) begin
         case (phase_in)
            PH_CONTROL: begin
               if (prod_c >= expected_ff) begin
                  err_in = ST_TRAILING;
               end else begin
                  ctrl_in  = req_chan.token_byte;
                  bi_in    = 3'd7;
                  phase_in = req_chan.token_byte[7] ? PH_LITERAL : PH_DIST_LO;
               end
            end
            PH_LITERAL: begin
               kind    = CMD_LIT;
               prod_in = prod_c + 32'd1;
            end
            PH_DIST_LO: begin
               dlo_in   = req_chan.token_byte;
               phase_in = PH_DIST_HI;
            end
            PH_DIST_HI: begin
               dhi_in   = req_chan.token_byte;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (match_dist == 16'd0) begin
                  err_in = ST_ZERO_DIST;
               end else if (17'(match_dist) > 17'(WINDOW_SIZE)) begin
                  err_in = ST_WINDOW;
               end else if (32'(match_dist) > prod_c) begin
                  err_in = ST_PRODUCED;
               end else if ({1'b0, prod_c} + 33'(len) > {1'b0, expected_ff}) begin
                  err_in = ST_OVERRUN;
               end else begin
                  kind    = CMD_COPY;
                  prod_in = prod_c + 32'(len);
               end
            end
            default: begin
               err_in = ST_TRAILING;
            end
         endcase
         // finish the token
         if (kind != CMD_NONE) begin
            if (prod_in >= expected_ff) begin
               if (bi_in != 3'd0 &&
                   (ctrl_in & ((8'd1 << bi_in) - 8'd1)) != 8'd0) begin
                  err_in = ST_PADDING;
               end else begin
                  phase_in = PH_DONE;
               end
            end else if (bi_in == 3'd0) begin
               bi_in    = 3'd7;
               phase_in = PH_CONTROL;
            end else begin
               bi_in    = bi_in - 3'd1;
               phase_in = ctrl_in[bi_in] ? PH_LITERAL : PH_DIST_LO;
            end
         end
      end
      if (req_chan.final_byte && err_in == ST_OK) begin
         if (phase_in == PH_DONE) begin
            done = 1'b1;
         end else begin
            err_in = ST_TRUNCATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CONTROL;
         ctrl_ff  <= '0;
         bi_ff    <= 3'd7;
         dlo_ff   <= '0;
         dhi_ff   <= '0;
         err_ff   <= ST_OK;
         prod_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         ctrl_ff  <= ctrl_in;
         bi_ff    <= bi_in;
         dlo_ff   <= dlo_in;
         dhi_ff   <= dhi_in;
         err_ff   <= err_in;
         prod_ff  <= prod_in;
      end
   end

   // push the command
   assign cmd_valid         = accept;
   assign cmd_data.kind     = kind;
   assign cmd_data.lit      = req_chan.token_byte;
   assign cmd_data.offset   = match_dist[WIN_BITS-1:0];
   assign cmd_data.len      = len;
   assign cmd_data.base     = prod_c[WIN_BITS-1:0];
   assign cmd_data.status   = err_in;
   assign cmd_data.done     = done;
   assign cmd_data.produced = prod_in;

endmodule

// File: design/lzd_cmd_fifo.sv
`timescale 1ns / 1ps
module lzd_cmd_fifo import lzd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);

   cmd_type entry_ff [FIFO_DEPTH];
   logic [FIFO_IDX_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_IDX_BITS:0]   fill_ff, fill_in;

   assign not_full  = fill_ff != (FIFO_IDX_BITS+1)'(FIFO_DEPTH);
   assign not_empty = fill_ff != '0;
   assign pop_data  = entry_ff[rd_ff];

   always_comb begin
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (FIFO_IDX_BITS+1)'(push) - (FIFO_IDX_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: design/lzd_copy_engine.sv
`timescale 1ns / 1ps
module lzd_copy_engine import lzd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   lzd_rsp_if.source rsp_chan
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_RD   = 2'd1;
   localparam logic [1:0] B_WR   = 2'd2;
   localparam logic [1:0] B_EMIT = 2'd3;

   logic [7:0] hist_mem [WINDOW_SIZE];

   logic [1:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [WIN_BITS-1:0] src_ff, src_in, wr_ff, wr_in;
   logic [LEN_BITS-1:0] remain_ff, remain_in;
   logic [63:0]         word_ff, word_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                last_ff, last_in;
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic [WIN_BITS-1:0] mem_wa;
   logic [7:0]          mem_wd;
   logic                out_free;

   logic                rvalid_ff;
   logic [63:0]         rword_ff;
   logic [CNT_BITS-1:0] rcnt_ff;
   logic                rlast_ff;
   logic [2:0]          rstat_ff;
   logic                rdone_ff;
   logic [31:0]         rprod_ff;

   assign out_free = !rvalid_ff || rsp_chan.ready;

   // sequence one command
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      src_in    = src_ff;
      wr_in     = wr_ff;
      remain_in = remain_ff;
      word_in   = word_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = wr_ff;
      mem_wd    = rd_data_ff;
      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd_data;
               word_in   = '0;
               cnt_in    = '0;
               last_in   = 1'b1;
               src_in    = cmd_data.base - cmd_data.offset;
               wr_in     = cmd_data.base;
               remain_in = cmd_data.len;
               if (cmd_data.kind == CMD_LIT) begin
                  mem_we   = 1'b1;
                  mem_wa   = cmd_data.base;
                  mem_wd   = cmd_data.lit;
                  word_in  = 64'(cmd_data.lit);
                  cnt_in   = CNT_BITS'(1);
                  state_in = B_EMIT;
               end else if (cmd_data.kind == CMD_COPY) begin
                  state_in = B_RD;
               end else begin
                  state_in = B_EMIT;
               end
            end
         end
         B_RD: begin
            state_in = B_WR;
         end
         B_WR: begin
            mem_we    = 1'b1;
            src_in    = src_ff + 1'b1;
            wr_in     = wr_ff + 1'b1;
            word_in   = word_ff | (64'(rd_data_ff) << {cnt_ff, 3'b000});
            cnt_in    = cnt_ff + 1'b1;
            remain_in = remain_ff - 1'b1;
            if (remain_ff == LEN_BITS'(1)) begin
               last_in  = 1'b1;
               state_in = B_EMIT;
            end else if (cnt_in == CNT_BITS'(BYTES_PER_RESULT)) begin
               last_in  = 1'b0;
               state_in = B_EMIT;
            end else begin
               state_in = B_RD;
            end
         end
         default: begin
            if (out_free) begin
               word_in  = '0;
               cnt_in   = '0;
               state_in = last_ff ? B_IDLE : B_RD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff    <= cmd_in;
      src_ff    <= src_in;
      wr_ff     <= wr_in;
      remain_ff <= remain_in;
      word_ff   <= word_in;
      cnt_ff    <= cnt_in;
      last_ff   <= last_in;
   end

   // history memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= hist_mem[src_ff];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (state_ff == B_EMIT && out_free) begin
         rvalid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rvalid_ff <= 1'b0;
      end
      if (state_ff == B_EMIT && out_free) begin
         rword_ff <= word_ff;
         rcnt_ff  <= cnt_ff;
         rlast_ff <= last_ff;
         rstat_ff <= cmd_ff.status;
         rdone_ff <= cmd_ff.done;
         rprod_ff <= cmd_ff.produced;
      end
   end

   assign rsp_chan.valid          = rvalid_ff;
   assign rsp_chan.data_word      = rword_ff;
   assign rsp_chan.byte_count     = rcnt_ff;
   assign rsp_chan.last_of_run    = rlast_ff;
   assign rsp_chan.status         = rstat_ff;
   assign rsp_chan.stream_done    = rdone_ff;
   assign rsp_chan.bytes_produced = rprod_ff;

endmodule

// File: design/lzss_token_decoder_core.sv
`timescale 1ns / 1ps
// channel    dir  beat contents
// req_chan   in   token_byte, first_byte, final_byte
// rsp_chan   out  data_word, byte_count, last_of_run, status, stream_done,
//                 bytes_produced
// csr_chan   in   wdata = expected_size
//
// The parser takes a token byte whenever the command queue has room. In
// the copy engine a literal or an empty step is taken from the queue and
// then emitted; a match is taken, then each copied byte is read and then
// written (one history read port), and each full or final word is emitted.
// Reset is synchronous; history is not cleared. Either side may stall; the
// queue decouples them.
module lzss_token_decoder_core import lzd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lzd_req_if.sink   req_chan,
   lzd_csr_if.sink   csr_chan,
   lzd_rsp_if.source rsp_chan
);

   logic    push, not_full, pop, not_empty;
   cmd_type push_data, pop_data;

   lzd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .cmd_valid (push),
      .cmd_data  (push_data),
      .cmd_ready (not_full)
   );

   lzd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   lzd_copy_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (not_empty),
      .cmd_data  (pop_data),
      .cmd_pop   (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: tb/sv/tb_scoreboard.sv
`timescale 1ns / 1ps
package tb_lzd_pkg;
   import lzd_pkg::*;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_of_run;
      logic [2:0]  status;
      logic        stream_done;
      logic [31:0] bytes_produced;
   } word_beat_t;

   class lzss_scoreboard;
      // decoder state mirror
      logic [7:0]  history [WINDOW_SIZE];
      logic [31:0] produced;
      logic [2:0]  phase;
      logic [7:0]  ctrl;
      logic [3:0]  bit_idx;
      logic [7:0]  dist_lo;
      logic [7:0]  dist_hi;
      logic [2:0]  err;
      logic [31:0] size_limit;
      logic [7:0]  emitted [$];
      word_beat_t  pending_words [$];
      int          mismatches;

      function void clear_parser();
         produced = 0;
         phase = PH_CONTROL;
         ctrl = 0;
         bit_idx = 7;
         dist_lo = 0;
         dist_hi = 0;
         err = ST_OK;
      endfunction

      function new();
         clear_parser();
         size_limit = 0;
         mismatches = 0;
      endfunction

      function void put_byte(logic [7:0] v);
         history[produced % WINDOW_SIZE] = v;
         produced++;
         emitted.insert(emitted.size(), v);
      endfunction

      function logic [2:0] bit_phase();
         return ctrl[bit_idx[2:0]] ? PH_LITERAL : PH_DIST_LO;
      endfunction

      // close a token: finish, check padding or step to the next bit
      function void end_token();
         logic [7:0] mask;
         if (produced >= size_limit) begin
            mask = (8'd1 << bit_idx) - 8'd1;
            if (bit_idx > 0 && bit_idx <= 7 && (ctrl & mask) != 0) err = ST_PADDING;
            else phase = PH_DONE;
            return;
         end
         if (bit_idx == 0 || bit_idx > 7) begin
            bit_idx = 7;
            phase = PH_CONTROL;
         end else begin
            bit_idx--;
            phase = bit_phase();
         end
      endfunction

      function void run_copy(logic [7:0] len_byte);
         logic [31:0] span;
         logic [31:0] len;
         span = {dist_hi, dist_lo};
         len = len_byte + MIN_MATCH;
         if (span == 0) begin err = ST_ZERO_DIST; return; end
         if (span > WINDOW_SIZE) begin err = ST_WINDOW; return; end
         if (span > produced) begin err = ST_PRODUCED; return; end
         if ({32'd0, produced} + len > {32'd0, size_limit}) begin
            err = ST_OVERRUN;
            return;
         end
         for (int i = 0; i < len; i++) put_byte(history[(produced - span) % WINDOW_SIZE]);
         end_token();
      endfunction

      // note an accepted token beat and queue the words it yields
      function void note_token(logic [7:0] b, logic first, logic fin);
         logic done;
         int nwords;
         word_beat_t w;
         done = 0;
         emitted.delete();
         if (first) clear_parser();
         if (err == ST_OK) begin
            case (phase)
               PH_CONTROL: begin
                  if (produced >= size_limit) err = ST_TRAILING;
                  else begin
                     ctrl = b;
                     bit_idx = 7;
                     phase = bit_phase();
                  end
               end
               PH_LITERAL: begin put_byte(b); end_token(); end
               PH_DIST_LO: begin dist_lo = b; phase = PH_DIST_HI; end
               PH_DIST_HI: begin dist_hi = b; phase = PH_LENGTH; end
               PH_LENGTH: run_copy(b);
               default: err = ST_TRAILING;
            endcase
         end
         if (fin && err == ST_OK) begin
            if (phase == PH_DONE) done = 1;
            else err = ST_TRUNCATED;
         end
         nwords = (emitted.size() + 7) / 8;
         if (nwords == 0) nwords = 1;
         for (int k = 0; k < nwords; k++) begin
            w = '0;
            for (int j = 0; j < 8 && k * 8 + j < emitted.size(); j++) begin
               w.data_word[8*j +: 8] = emitted[k*8+j];
               w.byte_count++;
            end
            w.last_of_run = (k + 1 == nwords);
            w.status = err;
            w.stream_done = done;
            w.bytes_produced = produced;
            pending_words.insert(pending_words.size(), w);
         end
      endfunction

      function void report(string what, logic [63:0] got, logic [63:0] want);
         mismatches++;
         $display("mismatch %s: got %0h want %0h", what, got, want);
      endfunction

      // compare one result beat against the oldest pending word
      function void check_word(word_beat_t got);
         word_beat_t want;
         if (pending_words.size() == 0) begin
            report("unexpected beat", got.data_word, 0);
            return;
         end
         want = pending_words.pop_front();
         if (got.data_word !== want.data_word) report("data_word", got.data_word, want.data_word);
         if (got.byte_count !== want.byte_count)
            report("byte_count", got.byte_count, want.byte_count);
         if (got.last_of_run !== want.last_of_run)
            report("last_of_run", got.last_of_run, want.last_of_run);
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.stream_done !== want.stream_done)
            report("stream_done", got.stream_done, want.stream_done);
         if (got.bytes_produced !== want.bytes_produced)
            report("bytes_produced", got.bytes_produced, want.bytes_produced);
      endfunction
   endclass
endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import lzd_pkg::*;
   import tb_lzd_pkg::*;

   typedef struct {
      logic [7:0] b;
      logic       first;
      logic       fin;
   } token_t;

   logic clock;
   logic reset;
   lzd_req_if req_chan ();
   lzd_rsp_if rsp_chan ();
   lzd_csr_if csr_chan ();

   lzss_token_decoder_core DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .csr_chan(csr_chan.sink), .rsp_chan(rsp_chan.source)
   );

   lzss_scoreboard sb;
   token_t     stream_q [$];
   logic [7:0] plain [$];
   int idle_pct;
   int stall_pct;
   int hold_off;
   longint cycles;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 3000000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall plus optional long hold-off
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_chan.ready <= 0;
         end else rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // check result beats
   always @(posedge clock) begin
      word_beat_t w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         w.data_word = rsp_chan.data_word;
         w.byte_count = rsp_chan.byte_count;
         w.last_of_run = rsp_chan.last_of_run;
         w.status = rsp_chan.status;
         w.stream_done = rsp_chan.stream_done;
         w.bytes_produced = rsp_chan.bytes_produced;
         sb.check_word(w);
      end
   end

   // drop valid while idling, hold the beat until accepted
   task automatic send_token(token_t t);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 0;
         @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.token_byte <= t.b;
      req_chan.first_byte <= t.first;
      req_chan.final_byte <= t.fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_token(t.b, t.first, t.fin);
      @(negedge clock);
   endtask

   task automatic flush_stream();
      while (stream_q.size() > 0) send_token(stream_q.pop_front());
   endtask

   task automatic wait_idle();
      req_chan.valid <= 0;
      while (sb.pending_words.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_size(logic [31:0] v);
      csr_chan.valid <= 1;
      csr_chan.wdata <= v;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      sb.size_limit = v;
      @(negedge clock);
      csr_chan.valid <= 0;
   endtask

   task automatic push_tok(logic [7:0] b);
      token_t t;
      t.b = b;
      t.first = (stream_q.size() == 0);
      t.fin = 0;
      stream_q.insert(stream_q.size(), t);
   endtask

   // build a well-formed stream of n tokens; returns decoded size
   task automatic build_stream(int n, int lit_pct, int maxlen, output int total);
      logic [7:0] ctrl;
      int ctrl_pos;
      int span;
      int len;
      plain.delete();
      stream_q.delete();
      total = 0;
      for (int i = 0; i < n; i++) begin
         if (i % 8 == 0) begin
            ctrl_pos = stream_q.size();
            push_tok(8'h00);
            ctrl = 0;
         end
         if (total == 0 || $urandom_range(99) < lit_pct) begin
            ctrl[7 - i % 8] = 1;
            push_tok(8'($urandom_range(255)));
            total++;
         end else begin
            span = $urandom_range(1, total > WINDOW_SIZE ? WINDOW_SIZE : total);
            len = $urandom_range(0, maxlen);
            push_tok(span[7:0]);
            push_tok(span[15:8]);
            push_tok(len[7:0]);
            total += len + MIN_MATCH;
         end
         stream_q[ctrl_pos].b = ctrl;
      end
      stream_q[stream_q.size()-1].fin = 1;
   endtask

   task automatic run_stream(int n, int lit_pct, int maxlen, int corrupt);
      int total;
      int k;
      build_stream(n, lit_pct, maxlen, total);
      if (corrupt == 1) begin
         k = $urandom_range(0, stream_q.size()-1);
         stream_q[k].b = 8'($urandom_range(255));
      end else if (corrupt == 2) begin
         k = $urandom_range(1, stream_q.size()-1);
         stream_q[k].fin = 1;
      end
      flush_stream();
      wait_idle();
   endtask

   // set size from a stream built ahead of time, plus size_delta
   task automatic sized_stream(int n, int lit_pct, int maxlen, int size_delta);
      int total;
      build_stream(n, lit_pct, maxlen, total);
      write_size(total + size_delta);
      flush_stream();
      wait_idle();
   endtask

   task automatic dir(logic [7:0] b, logic first, logic fin);
      token_t t;
      t.b = b;
      t.first = first;
      t.fin = fin;
      send_token(t);
   endtask

   initial begin
      sb = new();
      idle_pct = 0;
      stall_pct = 0;
      hold_off = 0;
      reset = 1;
      req_chan.valid = 0;
      req_chan.token_byte = 0;
      req_chan.first_byte = 0;
      req_chan.final_byte = 0;
      csr_chan.valid = 0;
      csr_chan.wdata = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // size zero: every byte is trailing
      dir(8'hFF, 1, 1);
      wait_idle();
      write_size(32'hFFFF_FFFF);
      // literals, full-range bytes, early end
      dir(8'hFF, 1, 0); dir(8'h00, 0, 0); dir(8'hFF, 0, 0); dir(8'h5A, 0, 1);
      // match errors: zero distance, beyond window, beyond produced
      dir(8'h7F, 1, 0); dir(8'h00, 0, 0); dir(8'h00, 0, 0); dir(8'h00, 0, 0); dir(8'h00, 0, 0);
      dir(8'h7F, 1, 0); dir(8'h01, 0, 0); dir(8'h80, 0, 0); dir(8'h00, 0, 0); dir(8'h00, 0, 0);
      dir(8'h7F, 1, 0); dir(8'h11, 0, 0); dir(8'h02, 0, 0); dir(8'h00, 0, 0); dir(8'hFF, 0, 1);
      wait_idle();
      // overrun, a copy beyond produced, then overlapping max-length copy that completes
      write_size(4);
      dir(8'h80, 1, 0); dir(8'h33, 0, 0); dir(8'h01, 0, 0); dir(8'h00, 0, 0); dir(8'h01, 0, 1);
      wait_idle();
      write_size(259);
      dir(8'h00, 1, 0); dir(8'h01, 0, 0); dir(8'h00, 0, 0); dir(8'hFF, 0, 0);
      wait_idle();
      write_size(256 + 3);
      dir(8'h80, 1, 0); dir(8'hC3, 0, 0); dir(8'h01, 0, 0); dir(8'h00, 0, 0); dir(8'hFF, 0, 1);
      wait_idle();
      // padding bits set, then trailing byte after done
      write_size(1);
      dir(8'h81, 1, 0); dir(8'h42, 0, 1);
      dir(8'h80, 1, 0); dir(8'h42, 0, 0); dir(8'h80, 0, 1);
      wait_idle();

      // random phases
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 33) : 0;
         stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 33) : 0;
         if (ph == 0) begin
            // long receiver hold-off against a stream big enough to fill the block
            hold_off = 400;
            sized_stream(14, 70, 12, 0);
         end
         for (int s = 0; s < 5; s++) begin
            case ($urandom_range(5))
               0: sized_stream($urandom_range(1, 12), 60, 20, $urandom_range(0, 1));
               1: begin
                  write_size($urandom_range(0, 40));
                  run_stream($urandom_range(1, 10), 50, 10, $urandom_range(0, 2));
               end
               2: sized_stream($urandom_range(1, 6), 30, 255, 0);
               default: sized_stream($urandom_range(1, 14), 70, 12, 0);
            endcase
         end
      end
      // a few random-noise bytes
      write_size($urandom_range(1, 50));
      for (int i = 0; i < 20; i++) dir(8'($urandom_range(255)), i == 0, i == 19);
      wait_idle();
      write_size(0);
      dir(8'h00, 1, 1);
      wait_idle();

      if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// File: filelist.f
design/lzd_pkg.sv
design/lzd_if.sv
design/lzd_parser.sv
design/lzd_cmd_fifo.sv
design/lzd_copy_engine.sv
design/lzss_token_decoder_core.sv
tb/sv/tb_scoreboard.sv
tb/sv/tb_top.sv
